>>> src/bar_integral_gravity_filter_top_defines.svh
`ifndef BAR_INTEGRAL_GRAVITY_FILTER_TOP_DEFINES_SVH
`define BAR_INTEGRAL_GRAVITY_FILTER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BIGF_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("bigf assertion failed");

// next-cycle implication, disabled during reset
`define BIGF_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("bigf assertion failed");

`endif

>>> src/bigf_pkg.sv
`timescale 1ns / 1ps

package bigf_pkg;

   localparam int BAR_COUNT = 512;
   localparam int BAR_AW    = $clog2(BAR_COUNT);

   localparam int BAR_W     = 9;
   localparam int LEVEL_W   = 24;
   localparam int SHOWN_W   = 26;
   localparam int FALL_W    = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DW    = 16;

   localparam int MUL_AW    = 24;
   localparam int MUL_BW    = 20;
   localparam int MUL_PW    = MUL_AW + MUL_BW;
   localparam int DROP_W    = 37;

   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_FACTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRAVITY_STEP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRAVITY_ENABLE  = 2'd2;

   localparam logic [15:0] INTEGRAL_FACTOR_RST = 16'd45875;
   localparam logic [15:0] GRAVITY_STEP_RST    = 16'd1448;
   localparam logic        GRAVITY_ENABLE_RST  = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 24'hFF_FFFF;
   localparam logic [FALL_W-1:0]  FALL_MAX  = 10'd1020;
   localparam logic [FALL_W:0]    FALL_INC  = 11'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_MEM,
      ST_MUL_FF,
      ST_MUL_DROP,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [15:0] integral_factor;
      logic [15:0] gravity_step;
      logic        gravity_enable;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]        integ;
      logic signed [SHOWN_W-1:0] last_shown;
      logic [LEVEL_W-1:0]        peak;
      logic [FALL_W-1:0]         fall;
   } bar_row_type;

   typedef struct packed {
      logic              rd_en;
      logic [BAR_AW-1:0] rd_addr;
      logic              wr_en;
      logic [BAR_AW-1:0] wr_addr;
      bar_row_type       wr_row;
   } mem_req_type;

   typedef struct packed {
      logic        clearing;
      bar_row_type rd_row;
   } mem_sts_type;

endpackage

>>> src/bigf_if.sv
`timescale 1ns / 1ps

interface bigf_req_if;
   logic        valid;
   logic        ready;
   logic [8:0]  bar_index;
   logic [23:0] bar_level;

   modport source (output valid, output bar_index, output bar_level, input ready);
   modport sink   (input valid, input bar_index, input bar_level, output ready);
endinterface

interface bigf_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  bar_number;
   logic [23:0] shown_level;

   modport source (output valid, output bar_number, output shown_level, input ready);
   modport sink   (input valid, input bar_number, input shown_level, output ready);
endinterface

>>> src/bar_integral_gravity_filter_top.sv
`timescale 1ns / 1ps
// Bar integral and gravity filter for a spectrum display.
// req channel: one transfer carries bar_index and bar_level (unsigned Q16.8).
// rsp channel: one transfer per request, bar_number echoed and shown_level,
//   the integral-smoothed level with gravity falloff, clamped at zero.
// csr port: csr_we writes csr_wdata to register csr_index on a clock edge:
//   0 integral_factor (Q0.16), 1 gravity_step (Q8.8), 2 gravity_enable;
//   other indexes are ignored. Write only while no request is in flight.
// Sequence: a bar in range passes ST_MUL_MEM, ST_MUL_FF, ST_MUL_DROP, ST_WRITE;
//   an index beyond the bar count goes straight to ST_WRITE. A new request is
//   taken only in ST_IDLE. The single shared 24x20 multiplier takes three passes
//   per bar (memory times factor, fall count squared, step times that square).
// Reset: synchronous, active high. Registers return to their defaults and the
//   per-bar store is swept to zero, one bar per cycle, during which req ready
//   stays low.
// Stall: the result waits in the output register; the next request may be
//   taken and processed meanwhile, and it holds in its final step until the
//   output register is free.

module bar_integral_gravity_filter_top (
   input  logic                           clock,
   input  logic                           reset,
   bigf_req_if.sink                       req,
   bigf_rsp_if.source                     rsp,
   input  logic                           csr_we,
   input  logic [bigf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bigf_pkg::CSR_DW-1:0]    csr_wdata
);

   bigf_pkg::cfg_type     cfg_ff;
   bigf_pkg::cfg_type     cfg_in;
   bigf_pkg::mem_req_type mem_req;
   bigf_pkg::mem_sts_type mem_sts;

   logic                        mul_en;
   logic [bigf_pkg::MUL_AW-1:0] mul_a;
   logic [bigf_pkg::MUL_BW-1:0] mul_b;
   logic [bigf_pkg::MUL_PW-1:0] product;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            bigf_pkg::REG_INTEGRAL_FACTOR: cfg_in.integral_factor = csr_wdata;
            bigf_pkg::REG_GRAVITY_STEP:    cfg_in.gravity_step    = csr_wdata;
            bigf_pkg::REG_GRAVITY_ENABLE:  cfg_in.gravity_enable  = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.integral_factor <= bigf_pkg::INTEGRAL_FACTOR_RST;
         cfg_ff.gravity_step    <= bigf_pkg::GRAVITY_STEP_RST;
         cfg_ff.gravity_enable  <= bigf_pkg::GRAVITY_ENABLE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bigf_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req     (req),
      .rsp     (rsp),
      .mem_req (mem_req),
      .mem_sts (mem_sts),
      .mul_en  (mul_en),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   bigf_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .mem_sts (mem_sts)
   );

   bigf_mul u_mul (
      .clock   (clock),
      .mul_en  (mul_en),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

endmodule

>>> src/bigf_mul.sv
`timescale 1ns / 1ps

module bigf_mul (
   input  logic                        clock,
   input  logic                        mul_en,
   input  logic [bigf_pkg::MUL_AW-1:0] mul_a,
   input  logic [bigf_pkg::MUL_BW-1:0] mul_b,
   output logic [bigf_pkg::MUL_PW-1:0] product
);

   logic [bigf_pkg::MUL_PW-1:0] product_ff;
   logic [bigf_pkg::MUL_PW-1:0] product_in;

   assign product_in = bigf_pkg::MUL_PW'(mul_a) * bigf_pkg::MUL_PW'(mul_b);

   // hold the last product while the sequencer is not issuing
   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

>>> src/bigf_mem.sv
`timescale 1ns / 1ps

module bigf_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  bigf_pkg::mem_req_type mem_req,
   output bigf_pkg::mem_sts_type mem_sts
);

   bigf_pkg::bar_row_type mem [bigf_pkg::BAR_COUNT];

   bigf_pkg::bar_row_type            rd_row_ff;
   logic                             clearing_ff;
   logic                             clearing_in;
   logic [bigf_pkg::BAR_AW-1:0]      clr_addr_ff;
   logic [bigf_pkg::BAR_AW-1:0]      clr_addr_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == bigf_pkg::BAR_AW'(bigf_pkg::BAR_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_row;
      end
      if (mem_req.rd_en) begin
         rd_row_ff <= mem[mem_req.rd_addr];
      end
   end

   assign mem_sts.clearing = clearing_ff;
   assign mem_sts.rd_row   = rd_row_ff;

endmodule

>>> src/bigf_core.sv
`timescale 1ns / 1ps
`include "bar_integral_gravity_filter_top_defines.svh"

module bigf_core (
   input  logic                  clock,
   input  logic                  reset,
   input  bigf_pkg::cfg_type     cfg,
   bigf_req_if.sink              req,
   bigf_rsp_if.source            rsp,
   output bigf_pkg::mem_req_type mem_req,
   input  bigf_pkg::mem_sts_type mem_sts,
   output logic                  mul_en,
   output logic [bigf_pkg::MUL_AW-1:0] mul_a,
   output logic [bigf_pkg::MUL_BW-1:0] mul_b,
   input  logic [bigf_pkg::MUL_PW-1:0] product
);

   bigf_pkg::state_type state_ff;
   bigf_pkg::state_type state_in;

   logic [bigf_pkg::BAR_W-1:0]   bar_ff;
   logic [bigf_pkg::LEVEL_W-1:0] level_ff;
   logic                         in_range_ff;
   logic [bigf_pkg::LEVEL_W-1:0] integ_ff;
   logic [bigf_pkg::LEVEL_W-1:0] integ_in;
   logic [bigf_pkg::LEVEL_W:0]   integ_sum;

   logic                         rsp_valid_ff;
   logic [bigf_pkg::BAR_W-1:0]   rsp_bar_ff;
   logic [bigf_pkg::LEVEL_W-1:0] rsp_level_ff;

   logic                         accept;
   logic                         in_range;
   logic                         load_out;

   logic [bigf_pkg::DROP_W-1:0]        drop;
   logic signed [bigf_pkg::DROP_W:0]   fall_value;
   logic signed [bigf_pkg::SHOWN_W-1:0] fall_result;
   logic signed [bigf_pkg::SHOWN_W-1:0] result;
   logic                                falling;
   logic [bigf_pkg::FALL_W:0]           fall_next;
   logic [bigf_pkg::LEVEL_W-1:0]        shown;
   bigf_pkg::bar_row_type               new_row;

   assign in_range = (32'(req.bar_index) < bigf_pkg::BAR_COUNT);
   assign accept   = req.valid && req.ready;

   // integral: memory times factor, truncated, plus level, saturating
   assign integ_sum = {1'b0, product[39:16]} + {1'b0, level_ff};
   assign integ_in  = integ_sum[bigf_pkg::LEVEL_W] ? bigf_pkg::LEVEL_MAX
                                                    : integ_sum[bigf_pkg::LEVEL_W-1:0];

   always_comb begin
      new_row     = mem_sts.rd_row;
      new_row.integ = integ_ff;
      drop        = product[bigf_pkg::DROP_W-1:0];
      fall_value  = $signed({{(bigf_pkg::DROP_W + 1 - bigf_pkg::LEVEL_W){1'b0}},
                             mem_sts.rd_row.peak})
                    - $signed({1'b0, drop});
      if (fall_value < -(39'sd1 <<< (bigf_pkg::SHOWN_W - 1))) begin
         fall_result = {1'b1, {(bigf_pkg::SHOWN_W - 1){1'b0}}};
      end else begin
         fall_result = fall_value[bigf_pkg::SHOWN_W-1:0];
      end
      fall_next = {1'b0, mem_sts.rd_row.fall} + bigf_pkg::FALL_INC;
      if (fall_next > {1'b0, bigf_pkg::FALL_MAX}) begin
         fall_next = {1'b0, bigf_pkg::FALL_MAX};
      end
      falling = cfg.gravity_enable &&
                ($signed({3'b000, integ_ff}) <
                 $signed({mem_sts.rd_row.last_shown[bigf_pkg::SHOWN_W-1],
                          mem_sts.rd_row.last_shown}));
      result = $signed({2'b00, integ_ff});
      if (cfg.gravity_enable) begin
         if (falling) begin
            result       = fall_result;
            new_row.fall = fall_next[bigf_pkg::FALL_W-1:0];
         end else begin
            new_row.peak = integ_ff;
            new_row.fall = '0;
         end
         new_row.last_shown = result;
      end
      if (!in_range_ff || result[bigf_pkg::SHOWN_W-1]) begin
         shown = '0;
      end else begin
         shown = result[bigf_pkg::LEVEL_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mem_req   = '0;
      req.ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         bigf_pkg::ST_IDLE: begin
            req.ready = !mem_sts.clearing;
            if (req.valid && !mem_sts.clearing) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = bigf_pkg::BAR_AW'(req.bar_index);
               state_in = in_range ? bigf_pkg::ST_MUL_MEM : bigf_pkg::ST_WRITE;
            end
         end
         bigf_pkg::ST_MUL_MEM: begin
            mul_en   = 1'b1;
            mul_a    = mem_sts.rd_row.integ;
            mul_b    = bigf_pkg::MUL_BW'(cfg.integral_factor);
            state_in = bigf_pkg::ST_MUL_FF;
         end
         bigf_pkg::ST_MUL_FF: begin
            mul_en   = 1'b1;
            mul_a    = bigf_pkg::MUL_AW'(mem_sts.rd_row.fall);
            mul_b    = bigf_pkg::MUL_BW'(mem_sts.rd_row.fall);
            state_in = bigf_pkg::ST_MUL_DROP;
         end
         bigf_pkg::ST_MUL_DROP: begin
            mul_en   = 1'b1;
            mul_a    = bigf_pkg::MUL_AW'(cfg.gravity_step);
            mul_b    = product[bigf_pkg::MUL_BW-1:0];
            state_in = bigf_pkg::ST_WRITE;
         end
         bigf_pkg::ST_WRITE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_out        = 1'b1;
               mem_req.wr_en   = in_range_ff;
               mem_req.wr_addr = bigf_pkg::BAR_AW'(bar_ff);
               mem_req.wr_row  = new_row;
               state_in        = bigf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bigf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bigf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bar_ff      <= req.bar_index;
         level_ff    <= req.bar_level;
         in_range_ff <= in_range;
      end
      if (state_ff == bigf_pkg::ST_MUL_FF) begin
         integ_ff <= integ_in;
      end
      if (load_out) begin
         rsp_bar_ff   <= bar_ff;
         rsp_level_ff <= shown;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.bar_number  = rsp_bar_ff;
   assign rsp.shown_level = rsp_level_ff;

   `BIGF_ASSERT_IMPLIES(a_no_accept_while_clearing, clock, reset, mem_sts.clearing, !req.ready)
   `BIGF_ASSERT_IMPLIES(a_write_in_range, clock, reset, mem_req.wr_en, in_range_ff)
   `BIGF_ASSERT_IMPLIES(a_fall_bounded, clock, reset, mem_req.wr_en, mem_req.wr_row.fall <= bigf_pkg::FALL_MAX)
   `BIGF_ASSERT_NEXT(a_out_after_write, clock, reset, load_out, rsp_valid_ff && state_ff == bigf_pkg::ST_IDLE)

endmodule

>>> tb/bar_integral_gravity_filter_top_tb.sv
`timescale 1ns / 1ps

class bar_filter_scoreboard;
   typedef struct {
      logic [bigf_pkg::BAR_W-1:0]   bar;
      logic [bigf_pkg::LEVEL_W-1:0] level;
   } bar_result;

   localparam longint SHOWN_FLOOR = -33554432;

   logic [bigf_pkg::LEVEL_W-1:0]        integ_mem [bigf_pkg::BAR_COUNT];
   logic signed [bigf_pkg::SHOWN_W-1:0] shown_mem [bigf_pkg::BAR_COUNT];
   logic [bigf_pkg::LEVEL_W-1:0]        peak_mem  [bigf_pkg::BAR_COUNT];
   logic [bigf_pkg::FALL_W-1:0]         fall_mem  [bigf_pkg::BAR_COUNT];

   logic [15:0] factor;
   logic [15:0] fall_step;
   logic        gravity_on;

   bar_result expected_levels[$];
   int        errors;

   function new();
      factor     = bigf_pkg::INTEGRAL_FACTOR_RST;
      fall_step  = bigf_pkg::GRAVITY_STEP_RST;
      gravity_on = bigf_pkg::GRAVITY_ENABLE_RST;
      errors     = 0;
      for (int i = 0; i < bigf_pkg::BAR_COUNT; i++) begin
         integ_mem[i] = '0;
         shown_mem[i] = '0;
         peak_mem[i]  = '0;
         fall_mem[i]  = '0;
      end
   endfunction

   function void set_register(logic [bigf_pkg::CSR_IDX_W-1:0] idx,
                              logic [bigf_pkg::CSR_DW-1:0] data);
      case (idx)
         bigf_pkg::REG_INTEGRAL_FACTOR: factor = data;
         bigf_pkg::REG_GRAVITY_STEP:    fall_step = data;
         bigf_pkg::REG_GRAVITY_ENABLE:  gravity_on = data[0];
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_levels.size();
   endfunction

   function void note_request(logic [bigf_pkg::BAR_W-1:0] bar,
                              logic [bigf_pkg::LEVEL_W-1:0] level);
      longint    integ;
      longint    drop;
      longint    shown;
      longint    fall;
      bar_result res;
      res.bar = bar;
      if (bar >= bigf_pkg::BAR_COUNT) begin
         res.level = '0;
         expected_levels.push_back(res);
         return;
      end
      integ = ((longint'(integ_mem[bar]) * longint'(factor)) >> 16) + longint'(level);
      if (integ > longint'(bigf_pkg::LEVEL_MAX))
         integ = longint'(bigf_pkg::LEVEL_MAX);
      integ_mem[bar] = integ[bigf_pkg::LEVEL_W-1:0];
      shown = integ;
      if (gravity_on) begin
         if (integ < longint'(shown_mem[bar])) begin
            fall  = longint'(fall_mem[bar]);
            drop  = longint'(fall_step) * fall * fall;
            shown = longint'(peak_mem[bar]) - drop;
            if (shown < SHOWN_FLOOR)
               shown = SHOWN_FLOOR;
            fall = fall + 4;
            if (fall > longint'(bigf_pkg::FALL_MAX))
               fall = longint'(bigf_pkg::FALL_MAX);
            fall_mem[bar] = fall[bigf_pkg::FALL_W-1:0];
         end else begin
            peak_mem[bar] = integ[bigf_pkg::LEVEL_W-1:0];
            fall_mem[bar] = '0;
         end
         shown_mem[bar] = shown[bigf_pkg::SHOWN_W-1:0];
      end
      if (shown < 0)
         shown = 0;
      res.level = shown[bigf_pkg::LEVEL_W-1:0];
      expected_levels.push_back(res);
   endfunction

   task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task check_response(logic [bigf_pkg::BAR_W-1:0] bar,
                       logic [bigf_pkg::LEVEL_W-1:0] level);
      bar_result res;
      if (expected_levels.size() == 0) begin
         report_mismatch($sformatf("unexpected transfer, bar %0d level %h", bar, level));
         return;
      end
      res = expected_levels.pop_front();
      if (bar !== res.bar)
         report_mismatch($sformatf("bar_number %0d, want %0d", bar, res.bar));
      if (level !== res.level)
         report_mismatch($sformatf("bar %0d shown_level %h, want %h",
                                   res.bar, level, res.level));
   endtask
endclass

module bar_integral_gravity_filter_top_tb;
   import bigf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 10;
   localparam int STUCK_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DW-1:0]    csr_wdata;

   bigf_req_if req_if ();
   bigf_rsp_if rsp_if ();

   bar_filter_scoreboard sb;

   int stuck_cycles;
   int hold_request;
   int sender_rush;
   int req_quiet_left;
   bit req_quiet;
   int rsp_quiet_left;
   bit rsp_quiet;

   bar_integral_gravity_filter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic int draw_gap(inout int left, inout bit quiet);
      if (left == 0) begin
         left  = $urandom_range(10, 60);
         quiet = ($urandom_range(0, 3) == 0);
      end
      left--;
      if (quiet)
         return 0;
      return $urandom_range(0, 11);
   endfunction

   function automatic logic [BAR_W-1:0] pick_bar();
      if ($urandom_range(0, 1) == 1)
         return BAR_W'($urandom_range(0, BAR_COUNT - 1));
      return BAR_W'($urandom_range(0, 3) + (($urandom_range(0, 1) == 1) ? BAR_COUNT - 4 : 0));
   endfunction

   function automatic logic [LEVEL_W-1:0] high_level();
      if ($urandom_range(0, 3) == 0)
         return LEVEL_MAX;
      return LEVEL_W'($urandom_range(24'h100000, 24'hFFFFFF));
   endfunction

   function automatic logic [LEVEL_W-1:0] low_level();
      logic [LEVEL_W-1:0] lvl;
      lvl = LEVEL_W'($urandom_range(0, 24'hFFFFFF));
      return lvl >> $urandom_range(0, 24);
   endfunction

   task automatic send_request(input logic [BAR_W-1:0] bar, input logic [LEVEL_W-1:0] level);
      int gap;
      gap = draw_gap(req_quiet_left, req_quiet);
      if (sender_rush > 0) begin
         gap = 0;
         sender_rush--;
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.bar_index <= bar;
      req_if.bar_level <= level;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(bar, level);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic configure(input logic [15:0] factor, input logic [15:0] fall_step,
                            input logic gravity_on, input bit spare_write);
      write_register(REG_INTEGRAL_FACTOR, factor);
      write_register(REG_GRAVITY_STEP, fall_step);
      write_register(REG_GRAVITY_ENABLE, {15'($urandom), gravity_on});
      if (spare_write)
         write_register(REG_SPARE, 16'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input logic [15:0] factor, input logic [15:0] fall_step,
                            input logic gravity_on, input int count);
      int                 sent;
      int                 len;
      logic [BAR_W-1:0]   bar;
      settle();
      configure(factor, fall_step, gravity_on, $urandom_range(0, 1) == 1);
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 3) != 0) begin
            bar = pick_bar();
            len = $urandom_range(3, 30);
            send_request(bar, high_level());
            for (int i = 1; i < len; i++)
               send_request(bar, ($urandom_range(0, 7) == 0) ? high_level() : low_level());
            sent += len;
         end else begin
            send_request(BAR_W'($urandom_range(0, BAR_COUNT - 1)),
                         LEVEL_W'($urandom_range(0, 24'hFFFFFF)));
            sent++;
         end
      end
   endtask

   initial begin : rsp_side
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = draw_gap(rsp_quiet_left, rsp_quiet);
         if (hold_request > 0) begin
            stall        = hold_request;
            hold_request = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         sb.check_response(rsp_if.bar_number, rsp_if.shown_level);
      end
   end

   initial begin : req_side
      sb               = new();
      stuck_cycles     = 0;
      hold_request     = 0;
      sender_rush      = 0;
      req_quiet_left   = 0;
      rsp_quiet_left   = 0;
      req_if.valid     = 1'b0;
      req_if.bar_index = '0;
      req_if.bar_level = '0;
      rsp_if.ready     = 1'b0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(9'd0, 24'd0);
      send_request(9'd511, LEVEL_MAX);
      send_request(9'd511, LEVEL_MAX);
      send_request(9'd511, 24'd0);
      send_request(9'd511, 24'd0);
      send_request(9'd511, 24'd0);
      send_request(9'd511, 24'd0);
      send_request(9'd511, LEVEL_MAX);
      send_request(9'd256, 24'd1);
      send_request(9'd256, 24'h800000);
      send_request(9'd256, 24'h7FFFFF);
      send_request(9'd0, 24'hAAAAAA);
      send_request(9'd0, 24'h555555);

      settle();
      configure(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      send_request(9'd7, 24'd1000);
      send_request(9'd7, 24'd0);
      send_request(9'd7, 24'd0);
      send_request(9'd7, 24'd0);

      settle();
      configure(16'h0000, 16'h00FF, 1'b0, 1'b1);
      send_request(9'd511, 24'd5);
      send_request(9'd511, 24'd0);
      send_request(9'd7, LEVEL_MAX);

      run_phase(INTEGRAL_FACTOR_RST, GRAVITY_STEP_RST, 1'b1, 200);

      // hold a decaying bar long enough to pin its fall count at the top
      run_phase(16'h0000, 16'h0001, 1'b1, 120);
      send_request(9'd3, LEVEL_MAX);
      repeat (300) send_request(9'd3, LEVEL_W'($urandom_range(0, 24'h0FFFFF)));

      run_phase(16'hFFFF, 16'hFFFF, 1'b1, 200);
      run_phase(16'($urandom), 16'($urandom), 1'b0, 180);

      settle();
      hold_request = HOLD_CYCLES;
      sender_rush  = 60;
      run_phase(16'($urandom), 16'($urandom_range(1, 64)), 1'b1, 200);

      run_phase(16'h0000, 16'hFFFF, 1'b1, 150);
      run_phase(16'($urandom), 16'($urandom), 1'b1, 200);

      settle();
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
